// ===== hdl/ghsp_pkg.sv =====
package ghsp_pkg;

    // ascii codes of the sentence
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // field numbers that carry a number
    localparam logic [3:0] FLD_WEEK      = 4'd1;
    localparam logic [3:0] FLD_HEADING   = 4'd3;
    localparam logic [3:0] FLD_PITCH     = 4'd4;
    localparam logic [3:0] FLD_LATITUDE  = 4'd6;
    localparam logic [3:0] FLD_LONGITUDE = 4'd7;
    localparam logic [3:0] FLD_ALTITUDE  = 4'd8;
    localparam logic [3:0] FLD_FRONT     = 4'd13;
    localparam logic [3:0] FLD_REAR      = 4'd14;
    localparam logic [3:0] FLD_MAX       = 4'd15;

    // capture slots
    localparam logic [2:0] SLOT_WEEK      = 3'd0;
    localparam logic [2:0] SLOT_HEADING   = 3'd1;
    localparam logic [2:0] SLOT_PITCH     = 3'd2;
    localparam logic [2:0] SLOT_LATITUDE  = 3'd3;
    localparam logic [2:0] SLOT_LONGITUDE = 3'd4;
    localparam logic [2:0] SLOT_ALTITUDE  = 3'd5;
    localparam logic [2:0] SLOT_FRONT     = 3'd6;
    localparam logic [2:0] SLOT_REAR      = 3'd7;
    localparam int         NUM_SLOTS      = 8;

    localparam logic [47:0] OUT_LIMIT  = 48'h7FFF_FFFF_FFFF;
    localparam logic [15:0] WEEK_LIMIT = 16'hFFFF;
    localparam logic [6:0]  SATS_LIMIT = 7'd99;

    typedef enum logic [2:0] {
        CLS_DOLLAR,
        CLS_COMMA,
        CLS_STAR,
        CLS_DIGIT,
        CLS_POINT,
        CLS_MINUS,
        CLS_PLUS,
        CLS_OTHER
    } t_byte_cls;

    typedef struct packed {
        logic       fire;
        t_byte_cls  cls;
        logic [3:0] digit;
    } t_beat_cmd;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_slot_sel;

    typedef struct packed {
        logic        [15:0] gps_week;
        logic signed [47:0] heading;
        logic signed [47:0] pitch;
        logic signed [47:0] latitude;
        logic signed [47:0] longitude;
        logic signed [47:0] altitude;
        logic        [6:0]  sats_front;
        logic        [6:0]  sats_rear;
    } t_record;

    function automatic t_byte_cls classify(input logic [7:0] b);
        t_byte_cls c;
        case (b) inside
            CH_DOLLAR:          c = CLS_DOLLAR;
            CH_COMMA:           c = CLS_COMMA;
            CH_STAR:            c = CLS_STAR;
            [CH_ZERO:CH_NINE]:  c = CLS_DIGIT;
            CH_POINT:           c = CLS_POINT;
            CH_MINUS:           c = CLS_MINUS;
            CH_PLUS:            c = CLS_PLUS;
            default:            c = CLS_OTHER;
        endcase
        return c;
    endfunction

    function automatic t_slot_sel slot_of(input logic [3:0] f);
        t_slot_sel s;
        s.hit = 1'b1;
        case (f)
            FLD_WEEK:      s.idx = SLOT_WEEK;
            FLD_HEADING:   s.idx = SLOT_HEADING;
            FLD_PITCH:     s.idx = SLOT_PITCH;
            FLD_LATITUDE:  s.idx = SLOT_LATITUDE;
            FLD_LONGITUDE: s.idx = SLOT_LONGITUDE;
            FLD_ALTITUDE:  s.idx = SLOT_ALTITUDE;
            FLD_FRONT:     s.idx = SLOT_FRONT;
            FLD_REAR:      s.idx = SLOT_REAR;
            default: begin
                s.hit = 1'b0;
                s.idx = SLOT_WEEK;
            end
        endcase
        return s;
    endfunction

    function automatic logic is_count(input logic [2:0] idx);
        return (idx == SLOT_WEEK) || (idx == SLOT_FRONT) || (idx == SLOT_REAR);
    endfunction

    // powers of ten for fraction digit weights
    function automatic logic [29:0] pow10(input logic [3:0] e);
        logic [29:0] p;
        case (e)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/ghsp_byte_if.sv =====
interface ghsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/ghsp_rec_if.sv =====
interface ghsp_rec_if;
    logic               valid;
    logic               ready;
    logic        [15:0] gps_week;
    logic signed [47:0] heading;
    logic signed [47:0] pitch;
    logic signed [47:0] latitude;
    logic signed [47:0] longitude;
    logic signed [47:0] altitude;
    logic        [6:0]  sats_front;
    logic        [6:0]  sats_rear;

    modport source (
        output valid, output gps_week, output heading, output pitch,
        output latitude, output longitude, output altitude,
        output sats_front, output sats_rear, input ready
    );
    modport sink (
        input valid, input gps_week, input heading, input pitch,
        input latitude, input longitude, input altitude,
        input sats_front, input sats_rear, output ready
    );
endinterface

// ===== hdl/gps_heading_sentence_parser.sv =====
// channel  | dir | beat payload                                    | fires when
// ---------+-----+-------------------------------------------------+----------------------
// i_rx     | in  | rx_byte, one sentence character                 | valid && ready
// o_rec    | out | gps_week, heading, pitch, latitude, longitude,  | valid && ready
//          |     | altitude, sats_front, sats_rear                 |
//
// one byte per cycle sustained while no '*' waits; a record's '*' beat passes
// the byte register and then the record register, which holds the record;
// all other bytes never stall
// a '*' beat waits in the byte register only while the record register is full
// and not taken, so input back pressure lasts as long as the record sink stalls
// synchronous active-low reset clears all parse state and captured values at once
module gps_heading_sentence_parser #(
    parameter int VALUE_BITS      = 48,
    parameter int FRACTION_DIGITS = 7
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ghsp_byte_if.sink  i_rx,
    ghsp_rec_if.source o_rec
);
    import ghsp_pkg::*;

    localparam int MAG_W = VALUE_BITS - 1;

    // byte register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // record register
    logic    r_out_valid;
    t_record r_rec;

    t_byte_cls cls;
    logic      out_free;
    logic      proc;
    t_beat_cmd cmd;
    t_record   rec_next;

    logic [NUM_SLOTS-1:0][MAG_W-1:0] slot_mag;
    logic [NUM_SLOTS-1:0]            slot_neg;

    always_comb begin
        cls      = classify(r_in_byte);
        out_free = !r_out_valid || o_rec.ready;
        // only a '*' needs room in the record register
        proc     = r_in_valid && ((cls != CLS_STAR) || out_free);
        cmd.fire  = proc;
        cmd.cls   = cls;
        cmd.digit = 4'(r_in_byte - CH_ZERO);
    end

    assign i_rx.ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    ghsp_field_acc #(
        .VALUE_BITS      (VALUE_BITS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_mag   (slot_mag),
        .o_neg   (slot_neg)
    );

    // captured slots are read before this beat's update, which a '*' never makes
    ghsp_record_fmt #(
        .VALUE_BITS (VALUE_BITS)
    ) u_fmt (
        .i_mag (slot_mag),
        .i_neg (slot_neg),
        .o_rec (rec_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && (cls == CLS_STAR)) begin
            r_out_valid <= 1'b1;
        end else if (o_rec.ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc && (cls == CLS_STAR)) begin
            r_rec <= rec_next;
        end
    end

    assign o_rec.valid      = r_out_valid;
    assign o_rec.gps_week   = r_rec.gps_week;
    assign o_rec.heading    = r_rec.heading;
    assign o_rec.pitch      = r_rec.pitch;
    assign o_rec.latitude   = r_rec.latitude;
    assign o_rec.longitude  = r_rec.longitude;
    assign o_rec.altitude   = r_rec.altitude;
    assign o_rec.sats_front = r_rec.sats_front;
    assign o_rec.sats_rear  = r_rec.sats_rear;

`ifndef SYNTHESIS
    a_star_makes_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && (cls == CLS_STAR)) |=> o_rec.valid)
        else $error("record missing after star beat");

    a_plain_bytes_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (cls != CLS_STAR)) |-> proc)
        else $error("non-star byte stalled");

    a_stall_only_on_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> (r_in_valid && (cls == CLS_STAR) && r_out_valid && !o_rec.ready))
        else $error("input stalled without a pending record");

    a_record_leaves_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(o_rec.ready))
        else $error("record dropped without being taken");
`endif

endmodule

// ===== hdl/ghsp_field_acc.sv =====
module ghsp_field_acc #(
    parameter int VALUE_BITS      = 48,
    parameter int FRACTION_DIGITS = 7
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ghsp_pkg::t_beat_cmd                   i_cmd,
    output logic [ghsp_pkg::NUM_SLOTS-1:0][VALUE_BITS-2:0] o_mag,
    output logic [ghsp_pkg::NUM_SLOTS-1:0]        o_neg
);
    import ghsp_pkg::*;

    localparam int MAG_W  = VALUE_BITS - 1;
    localparam int WIDE_W = MAG_W + 5;
    localparam int FD_W   = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
    localparam logic [MAG_W-1:0]  MAG_LIMIT = {MAG_W{1'b1}};
    localparam logic [33:0]       POW_F     = 34'(10 ** FRACTION_DIGITS);

    logic [3:0]       r_field;
    logic [MAG_W-1:0] r_acc;
    logic             r_neg;
    logic             r_point;
    logic [FD_W-1:0]  r_frac;
    logic             r_ended;
    logic             r_closed;
    logic [NUM_SLOTS-1:0][MAG_W-1:0] r_mag;
    logic [NUM_SLOTS-1:0]            r_sneg;

    t_slot_sel        slot;
    logic             cnt;
    logic [33:0]      int_b;
    logic [33:0]      frac_b;
    logic [3:0]       frac_exp;
    logic [WIDE_W-1:0] int_sum;
    logic [WIDE_W-1:0] frac_sum;
    logic             frac_take;
    logic [MAG_W-1:0] n_acc;
    logic [FD_W-1:0]  n_frac;

    always_comb begin
        slot      = slot_of(r_field);
        cnt       = is_count(slot.idx);
        int_b     = cnt ? 34'(i_cmd.digit) : 34'(i_cmd.digit) * POW_F;
        // accumulator times ten as two shifted copies
        int_sum   = (WIDE_W'(r_acc) << 3) + (WIDE_W'(r_acc) << 1) + WIDE_W'(int_b);
        frac_take = !cnt && (r_frac < FD_W'(FRACTION_DIGITS));
        frac_exp  = 4'(FRACTION_DIGITS) - 4'(r_frac) - 4'd1;
        frac_b    = 34'(i_cmd.digit) * 34'(pow10(frac_exp));
        frac_sum  = WIDE_W'(r_acc) + WIDE_W'(frac_b);
        n_acc     = r_acc;
        n_frac    = r_frac;
        if (r_point) begin
            if (frac_take) begin
                n_frac = r_frac + FD_W'(1);
                n_acc  = (frac_sum > WIDE_W'(MAG_LIMIT)) ? MAG_LIMIT : frac_sum[MAG_W-1:0];
            end
        end else begin
            n_acc = (int_sum > WIDE_W'(MAG_LIMIT)) ? MAG_LIMIT : int_sum[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field  <= '0;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_point  <= 1'b0;
            r_frac   <= '0;
            r_ended  <= 1'b0;
            r_closed <= 1'b0;
            r_mag    <= '0;
            r_sneg   <= '0;
        end else if (i_cmd.fire) begin
            case (i_cmd.cls)
                CLS_DOLLAR: begin
                    r_field  <= '0;
                    r_acc    <= '0;
                    r_neg    <= 1'b0;
                    r_point  <= 1'b0;
                    r_frac   <= '0;
                    r_ended  <= 1'b0;
                    r_closed <= 1'b0;
                    r_mag    <= '0;
                    r_sneg   <= '0;
                end
                CLS_COMMA: begin
                    if (r_field != FLD_MAX) begin
                        r_field <= r_field + 4'd1;
                    end
                    r_acc    <= '0;
                    r_neg    <= 1'b0;
                    r_point  <= 1'b0;
                    r_frac   <= '0;
                    r_ended  <= 1'b0;
                    r_closed <= 1'b0;
                end
                CLS_STAR: begin
                    r_ended <= 1'b1;
                end
                CLS_DIGIT: begin
                    if (slot.hit && !r_ended) begin
                        r_acc              <= n_acc;
                        r_frac             <= n_frac;
                        r_closed           <= 1'b1;
                        r_mag[slot.idx]    <= n_acc;
                        r_sneg[slot.idx]   <= r_neg;
                    end
                end
                CLS_POINT: begin
                    if (slot.hit && !r_ended) begin
                        if (r_point) begin
                            r_ended <= 1'b1;
                        end else begin
                            r_point  <= 1'b1;
                            r_closed <= 1'b1;
                        end
                    end
                end
                CLS_MINUS, CLS_PLUS: begin
                    if (slot.hit && !r_ended) begin
                        if (r_closed) begin
                            r_ended <= 1'b1;
                        end else begin
                            r_closed         <= 1'b1;
                            r_neg            <= (i_cmd.cls == CLS_MINUS);
                            r_mag[slot.idx]  <= r_acc;
                            r_sneg[slot.idx] <= (i_cmd.cls == CLS_MINUS);
                        end
                    end
                end
                default: begin
                    if (slot.hit) begin
                        r_ended <= 1'b1;
                    end
                end
            endcase
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_sneg;

endmodule

// ===== hdl/ghsp_record_fmt.sv =====
module ghsp_record_fmt #(
    parameter int VALUE_BITS = 48
) (
    input  logic [ghsp_pkg::NUM_SLOTS-1:0][VALUE_BITS-2:0] i_mag,
    input  logic [ghsp_pkg::NUM_SLOTS-1:0]                 i_neg,
    output ghsp_pkg::t_record                              o_rec
);
    import ghsp_pkg::*;

    localparam int MAG_W = VALUE_BITS - 1;
    localparam int CMP_W = (MAG_W > 48) ? MAG_W : 48;

    logic [NUM_SLOTS-1:0][CMP_W-1:0] ext;
    logic [NUM_SLOTS-1:0][47:0]      clamped;
    logic [NUM_SLOTS-1:0][47:0]      signed_val;

    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            ext[s]        = CMP_W'(i_mag[s]);
            clamped[s]    = (ext[s] > CMP_W'(OUT_LIMIT)) ? OUT_LIMIT : ext[s][47:0];
            signed_val[s] = i_neg[s] ? (48'd0 - clamped[s]) : clamped[s];
        end

        // counts clamp to their limit and read zero when negative
        if (i_neg[SLOT_WEEK]) begin
            o_rec.gps_week = '0;
        end else begin
            o_rec.gps_week = (ext[SLOT_WEEK] > CMP_W'(WEEK_LIMIT)) ? WEEK_LIMIT
                                                                 : ext[SLOT_WEEK][15:0];
        end
        if (i_neg[SLOT_FRONT]) begin
            o_rec.sats_front = '0;
        end else begin
            o_rec.sats_front = (ext[SLOT_FRONT] > CMP_W'(SATS_LIMIT)) ? SATS_LIMIT
                                                                    : ext[SLOT_FRONT][6:0];
        end
        if (i_neg[SLOT_REAR]) begin
            o_rec.sats_rear = '0;
        end else begin
            o_rec.sats_rear = (ext[SLOT_REAR] > CMP_W'(SATS_LIMIT)) ? SATS_LIMIT
                                                                  : ext[SLOT_REAR][6:0];
        end

        o_rec.heading   = signed_val[SLOT_HEADING];
        o_rec.pitch     = signed_val[SLOT_PITCH];
        o_rec.latitude  = signed_val[SLOT_LATITUDE];
        o_rec.longitude = signed_val[SLOT_LONGITUDE];
        o_rec.altitude  = signed_val[SLOT_ALTITUDE];
    end

endmodule

// ===== verif/ghsp_record_checker.sv =====
module ghsp_record_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ghsp_byte_if i_rx,
    ghsp_rec_if  i_rec,
    output int   o_fail_count,
    output int   o_pending
);
    import ghsp_pkg::*;

    typedef longint unsigned t_mag;

    localparam int   VALUE_BITS  = 48;
    localparam int   FRAC_DIGITS = 7;
    localparam t_mag MAG_MAX     = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
    localparam int   NO_SLOT     = -1;

    // parse state of the sentence under way
    logic [3:0]  field_idx;
    t_mag        magnitude;
    bit          minus_seen;
    bit          point_seen;
    bit          number_done;
    bit          sign_locked;
    int          frac_taken;
    logic [47:0] captured [NUM_SLOTS];

    t_record     pending_records [$];
    int          fail_count = 0;
    int          records_seen = 0;
    bit          star_fired;
    t_record     new_record;

    assign o_fail_count = fail_count;

    function automatic t_mag ten_to(input int k);
        t_mag p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    function automatic int slot_for(input logic [3:0] f);
        case (f)
            FLD_WEEK:      return SLOT_WEEK;
            FLD_HEADING:   return SLOT_HEADING;
            FLD_PITCH:     return SLOT_PITCH;
            FLD_LATITUDE:  return SLOT_LATITUDE;
            FLD_LONGITUDE: return SLOT_LONGITUDE;
            FLD_ALTITUDE:  return SLOT_ALTITUDE;
            FLD_FRONT:     return SLOT_FRONT;
            FLD_REAR:      return SLOT_REAR;
            default:       return NO_SLOT;
        endcase
    endfunction

    function automatic bit is_tally(input int slot);
        return slot == SLOT_WEEK || slot == SLOT_FRONT || slot == SLOT_REAR;
    endfunction

    function automatic t_mag add_sat(input t_mag a, input t_mag b);
        if (b > MAG_MAX || a > MAG_MAX - b) return MAG_MAX;
        return a + b;
    endfunction

    function automatic t_mag mul10_add_sat(input t_mag a, input t_mag b);
        if (b > MAG_MAX || a > (MAG_MAX - b) / 10) return MAG_MAX;
        return a * 10 + b;
    endfunction

    function automatic void clear_number();
        magnitude   = 0;
        minus_seen  = 1'b0;
        point_seen  = 1'b0;
        frac_taken  = 0;
        number_done = 1'b0;
        sign_locked = 1'b0;
    endfunction

    function automatic void clear_sentence();
        field_idx = '0;
        clear_number();
        foreach (captured[i]) captured[i] = '0;
    endfunction

    // counts clamp and drop negatives, scaled values clamp and carry the sign
    function automatic void latch_value(input int slot);
        t_mag m;
        t_mag lim;
        m = magnitude;
        if (is_tally(slot)) begin
            lim = (slot == SLOT_WEEK) ? t_mag'(WEEK_LIMIT) : t_mag'(SATS_LIMIT);
            captured[slot] = minus_seen ? 48'd0 : 48'(m > lim ? lim : m);
        end else begin
            if (m > t_mag'(OUT_LIMIT)) m = t_mag'(OUT_LIMIT);
            captured[slot] = minus_seen ? 48'(-m) : 48'(m);
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b, output bit fired,
                                       output t_record rec);
        int   slot;
        t_mag digit;
        fired = 1'b0;
        rec   = '0;
        if (b == CH_DOLLAR) begin
            clear_sentence();
        end else if (b == CH_COMMA) begin
            if (field_idx != FLD_MAX) field_idx++;
            clear_number();
        end else if (b == CH_STAR) begin
            number_done    = 1'b1;
            fired          = 1'b1;
            rec.gps_week   = captured[SLOT_WEEK][15:0];
            rec.heading    = captured[SLOT_HEADING];
            rec.pitch      = captured[SLOT_PITCH];
            rec.latitude   = captured[SLOT_LATITUDE];
            rec.longitude  = captured[SLOT_LONGITUDE];
            rec.altitude   = captured[SLOT_ALTITUDE];
            rec.sats_front = captured[SLOT_FRONT][6:0];
            rec.sats_rear  = captured[SLOT_REAR][6:0];
        end else begin
            slot = slot_for(field_idx);
            if (slot != NO_SLOT && !number_done) begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    digit = t_mag'(b - CH_ZERO);
                    if (point_seen) begin
                        if (!is_tally(slot) && frac_taken < FRAC_DIGITS) begin
                            frac_taken++;
                            magnitude = add_sat(magnitude,
                                                digit * ten_to(FRAC_DIGITS - frac_taken));
                        end
                    end else begin
                        magnitude = mul10_add_sat(magnitude, is_tally(slot) ?
                                                  digit : digit * ten_to(FRAC_DIGITS));
                    end
                    sign_locked = 1'b1;
                    latch_value(slot);
                end else if (b == CH_POINT) begin
                    if (point_seen) begin
                        number_done = 1'b1;
                    end else begin
                        point_seen  = 1'b1;
                        sign_locked = 1'b1;
                    end
                end else if (b == CH_MINUS || b == CH_PLUS) begin
                    if (sign_locked) begin
                        number_done = 1'b1;
                    end else begin
                        sign_locked = 1'b1;
                        minus_seen  = (b == CH_MINUS);
                        latch_value(slot);
                    end
                end else begin
                    number_done = 1'b1;
                end
            end
        end
    endfunction

    task automatic report_error(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
        if (got !== want)
            report_error($sformatf("record %0d %s got %0d want %0d",
                                   records_seen, name, got, want));
    endtask

    task automatic check_record();
        t_record want;
        if (pending_records.size() == 0) begin
            report_error($sformatf("record %0d arrived with none expected", records_seen));
        end else begin
            want = pending_records.pop_front();
            compare_field("gps_week", i_rec.gps_week, want.gps_week);
            compare_field("heading", i_rec.heading, want.heading);
            compare_field("pitch", i_rec.pitch, want.pitch);
            compare_field("latitude", i_rec.latitude, want.latitude);
            compare_field("longitude", i_rec.longitude, want.longitude);
            compare_field("altitude", i_rec.altitude, want.altitude);
            compare_field("sats_front", i_rec.sats_front, want.sats_front);
            compare_field("sats_rear", i_rec.sats_rear, want.sats_rear);
        end
        records_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sentence();
            pending_records.delete();
            o_pending <= 0;
        end else begin
            if (i_rec.valid && i_rec.ready) check_record();
            if (i_rx.valid && i_rx.ready) begin
                parse_byte(i_rx.rx_byte, star_fired, new_record);
                if (star_fired) pending_records.push_back(new_record);
            end
            o_pending <= pending_records.size();
        end
    end

endmodule

// ===== verif/gps_heading_sentence_parser_test.sv =====
module gps_heading_sentence_parser_test;
    import ghsp_pkg::*;

    // how a side spaces its beats over a stretch of items
    typedef enum int {
        PACE_FLAT_OUT,
        PACE_RANDOM,
        PACE_SPARSE
    } t_pace;

    localparam int STALL_LIMIT  = 500;   // cycles without any beat before giving up
    localparam int MIN_BYTES    = 1550;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [7:0] CH_HEX_A = "A";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_SPACE = " ";

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ghsp_byte_if rx_if ();
    ghsp_rec_if  rec_if ();

    int    fail_count;
    int    records_owed;
    int    bytes_sent     = 0;
    int    sentences_sent = 0;
    int    tx_left        = 0;
    int    rx_left        = 0;
    t_pace tx_pace        = PACE_FLAT_OUT;
    t_pace rx_pace        = PACE_FLAT_OUT;

    always #4 i_clk = ~i_clk;

    gps_heading_sentence_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_rec   (rec_if)
    );

    // predicts every record from the accepted bytes and compares
    ghsp_record_checker record_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_if),
        .i_rec        (rec_if),
        .o_fail_count (fail_count),
        .o_pending    (records_owed)
    );

    // per-item wait; the pace switches every few dozen items so that
    // long gap-free stretches alternate with heavy idling
    function automatic int draw_gap(inout int left, inout t_pace pace);
        if (left == 0) begin
            pace = t_pace'($urandom_range(0, 2));
            left = $urandom_range(20, 80);
        end
        left--;
        case (pace)
            PACE_FLAT_OUT: return 0;
            PACE_RANDOM:   return $urandom_range(0, 12);
            default:       return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input int n);
        return (n < 10) ? CH_ZERO + 8'(n) : CH_HEX_A + 8'(n - 10);
    endfunction

    // any byte but the ones that frame a sentence
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_DOLLAR || b == CH_COMMA || b == CH_STAR) b = CH_X;
        return b;
    endfunction

    // one beat: optional gap with valid low, then hold valid until taken;
    // valid gets a single assignment per edge so back-to-back beats stay high
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(tx_left, tx_pace);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!(rx_if.valid && rx_if.ready)) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_digit();
        send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // sign, integer digits (now and then enough to saturate), optional
    // fraction that may run past the kept digits, then maybe a bad tail
    task automatic send_number();
        int r;
        int n_int;
        r = $urandom_range(0, 5);
        if (r == 0) send_byte(CH_MINUS);
        else if (r == 1) send_byte(CH_PLUS);
        r = $urandom_range(0, 9);
        n_int = (r == 0) ? 0 :
                (r < 7)  ? $urandom_range(1, 3) :
                (r < 9)  ? $urandom_range(4, 6) : $urandom_range(7, 12);
        repeat (n_int) send_digit();
        if ($urandom_range(0, 1) == 1) begin
            send_byte(CH_POINT);
            repeat ($urandom_range(0, 9)) send_digit();
        end
        r = $urandom_range(0, 9);
        case (r)
            0:       send_byte(CH_POINT);
            1:       send_byte(($urandom_range(0, 1) == 1) ? CH_MINUS : CH_PLUS);
            2:       send_byte(CH_SPACE);
            3:       send_byte(junk_byte());
            default: ;
        endcase
        // digits after the number has ended must be ignored
        if (r < 4) repeat ($urandom_range(0, 2)) send_digit();
    endtask

    task automatic send_field();
        int r;
        r = $urandom_range(0, 9);
        if (r == 1) repeat ($urandom_range(1, 3)) send_byte(junk_byte());
        else if (r != 0) send_number();
    endtask

    // mostly well formed sentences with random content; about a third reach the
    // last numeric field and most of those run past it so the field counter saturates
    task automatic send_sentence();
        int n_fields;
        if ($urandom_range(0, 9) != 0) send_byte(CH_DOLLAR);
        if ($urandom_range(0, 3) != 0) send_text("GPHPD");
        n_fields = ($urandom_range(0, 2) == 0) ? $urandom_range(14, 17) : $urandom_range(0, 8);
        repeat (n_fields) begin
            send_byte(CH_COMMA);
            send_field();
        end
        send_byte(CH_STAR);
        send_byte(hex_char($urandom_range(0, 15)));
        send_byte(hex_char($urandom_range(0, 15)));
        // fields after the star still count and a second star emits again
        if ($urandom_range(0, 7) == 0) begin
            send_byte(CH_COMMA);
            send_field();
            send_byte(CH_STAR);
        end
        if ($urandom_range(0, 3) != 0) send_text("\r\n");
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    endtask

    // hold off the sender until every record owed has been taken
    task automatic wait_for_records();
        rx_if.valid <= 1'b0;
        do @(posedge i_clk); while (records_owed != 0);
    endtask

    // record side: random stall before each beat, ready held until taken
    initial begin : record_sink
        int stall;
        rec_if.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_gap(rx_left, rx_pace);
            if (stall > 0) begin
                rec_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rec_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(rec_if.valid && rec_if.ready)) @(posedge i_clk);
        end
    end

    // ends the run when neither channel moves a beat for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (rx_if.valid && rx_if.ready) || (rec_if.valid && rec_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL gps_heading_sentence_parser");
        $finish;
    end

    initial begin : byte_source
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // star before any dollar, week over its limit with a fraction,
        // saturated negative heading, pitch with extra fraction digits,
        // then a late sign in the latitude after the star
        send_text("*");
        send_text("$,70000.9,,-99999999,1.23456789*");
        send_text(",,+-5*");
        wait_for_records();

        while (bytes_sent < MIN_BYTES) begin
            send_sentence();
            sentences_sent++;
            if (sentences_sent % 16 == 3) wait_for_records();
        end
        rx_if.valid <= 1'b0;

        do @(posedge i_clk); while (records_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS gps_heading_sentence_parser");
        else
            $display("FAIL gps_heading_sentence_parser");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ghsp_pkg.sv
hdl/ghsp_byte_if.sv
hdl/ghsp_rec_if.sv
hdl/ghsp_field_acc.sv
hdl/ghsp_record_fmt.sv
hdl/gps_heading_sentence_parser.sv
verif/ghsp_record_checker.sv
verif/gps_heading_sentence_parser_test.sv
